>>> rtl/u8chk_pkg.sv
`default_nettype none

package u8chk_pkg;

   typedef logic [2:0] verdict_type;

   localparam verdict_type VERDICT_OK         = 3'd0;
   localparam verdict_type VERDICT_EMPTY      = 3'd1;
   localparam verdict_type VERDICT_TOO_LONG   = 3'd2;
   localparam verdict_type VERDICT_BAD_LEAD   = 3'd3;
   localparam verdict_type VERDICT_TRUNCATED  = 3'd4;
   localparam verdict_type VERDICT_NON_SCALAR = 3'd5;
   localparam verdict_type VERDICT_BAD_CONT   = 3'd6;
   localparam verdict_type VERDICT_CONTROL    = 3'd7;

   localparam int unsigned LEN_WIDTH = 17;
   localparam int unsigned MAX_WIDTH = 16;
   localparam logic [MAX_WIDTH-1:0] MAX_RESET = 16'd4096;

   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_DEL   = 8'h7f;
   localparam logic [7:0] LEAD2_LO    = 8'hc2;
   localparam logic [7:0] LEAD2_HI    = 8'hdf;
   localparam logic [7:0] LEAD3_LO    = 8'he0;
   localparam logic [7:0] LEAD3_HI    = 8'hef;
   localparam logic [7:0] LEAD4_LO    = 8'hf0;
   localparam logic [7:0] LEAD4_HI    = 8'hf4;
   localparam logic [7:0] LEAD_SURR   = 8'hed;
   localparam logic [7:0] CONT_LO     = 8'h80;
   localparam logic [7:0] CONT_HI     = 8'hbf;
   localparam logic [7:0] E0_MIN      = 8'ha0;
   localparam logic [7:0] ED_LIMIT    = 8'ha0;
   localparam logic [7:0] F0_MIN      = 8'h90;
   localparam logic [7:0] F4_MAX      = 8'h8f;
   localparam logic [20:0] C1_LAST    = 21'h9f;

   typedef struct packed {
      logic [1:0]           cont_left;
      logic [7:0]           lead;
      logic [1:0]           pos;
      logic [20:0]          codepoint;
      logic [LEN_WIDTH-1:0] len;
      verdict_type          committed;
      verdict_type          seq_err;
   } u8chk_state_type;

   localparam u8chk_state_type STATE_CLEAR = '0;

endpackage

`default_nettype wire

>>> rtl/u8chk_step.sv
`default_nettype none

module u8chk_step
   import u8chk_pkg::*;
(
   input  wire u8chk_state_type       state_cur,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  byte_present,
   input  wire logic [MAX_WIDTH-1:0]  max_text_bytes,
   output u8chk_state_type            state_nxt,
   output verdict_type                verdict
);

   always_comb begin
      u8chk_state_type st;
      logic            lead_ok;
      st      = state_cur;
      lead_ok = 1'b0;
      if (byte_present) begin
         if (!st.len[LEN_WIDTH-1]) begin
            st.len = st.len + LEN_WIDTH'(1);
         end
         if (st.cont_left == 2'd0) begin
            if (!data_byte[7]) begin
               if (data_byte < ASCII_SPACE || data_byte == ASCII_DEL) begin
                  if (st.committed == VERDICT_OK) st.committed = VERDICT_CONTROL;
               end
            end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
               st.cont_left = 2'd1;
               st.codepoint = {16'd0, data_byte[4:0]};
               lead_ok      = 1'b1;
            end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
               st.cont_left = 2'd2;
               st.codepoint = {17'd0, data_byte[3:0]};
               lead_ok      = 1'b1;
            end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
               st.cont_left = 2'd3;
               st.codepoint = {18'd0, data_byte[2:0]};
               lead_ok      = 1'b1;
            end else begin
               if (st.committed == VERDICT_OK) st.committed = VERDICT_BAD_LEAD;
            end
            if (lead_ok) begin
               st.lead    = data_byte;
               st.pos     = 2'd1;
               st.seq_err = VERDICT_OK;
            end
         end else begin
            // The second byte of a sequence carries the range limits of its lead.
            if (st.pos == 2'd1 && st.seq_err == VERDICT_OK) begin
               if ((st.lead == LEAD3_LO && data_byte < E0_MIN) ||
                   (st.lead == LEAD_SURR && data_byte >= ED_LIMIT) ||
                   (st.lead == LEAD4_LO && data_byte < F0_MIN) ||
                   (st.lead == LEAD4_HI && data_byte > F4_MAX)) begin
                  st.seq_err = VERDICT_NON_SCALAR;
               end
            end
            if (st.seq_err == VERDICT_OK && (data_byte < CONT_LO || data_byte > CONT_HI)) begin
               st.seq_err = VERDICT_BAD_CONT;
            end
            st.codepoint = {st.codepoint[14:0], data_byte[5:0]};
            st.cont_left = st.cont_left - 2'd1;
            st.pos       = st.pos + 2'd1;
            if (st.cont_left == 2'd0) begin
               if (st.committed == VERDICT_OK) begin
                  if (st.seq_err != VERDICT_OK) begin
                     st.committed = st.seq_err;
                  end else if (st.codepoint <= C1_LAST) begin
                     st.committed = VERDICT_CONTROL;
                  end
               end
               st.seq_err = VERDICT_OK;
               st.pos     = 2'd0;
            end
         end
      end
      state_nxt = st;
   end

   always_comb begin
      priority if (state_nxt.len == '0) begin
         verdict = VERDICT_EMPTY;
      end else if (state_nxt.len > {1'b0, max_text_bytes}) begin
         verdict = VERDICT_TOO_LONG;
      end else if (state_nxt.committed != VERDICT_OK) begin
         verdict = state_nxt.committed;
      end else if (state_nxt.cont_left != 2'd0) begin
         verdict = VERDICT_TRUNCATED;
      end else begin
         verdict = VERDICT_OK;
      end
   end

endmodule

`default_nettype wire

>>> rtl/utf8_identity_text_checker.sv
`default_nettype none

// Strict UTF-8 text checker. A text arrives one byte per request, the last request of a text
// carrying req_end_of_text, and one response with a verdict and the byte count follows each
// text. One request is taken in every clock cycle when the response side keeps up. A request
// is registered in the input register and checked from there when the second stage moves, which
// updates the text state and, for the last request of a text, loads the response register, from
// which the response is offered. While a response waits, a request in the input register is held
// there and no new one is accepted, though an empty input register still takes one. The length
// limit, written from csr_write_data into a register, is compared when the text ends.
module utf8_identity_text_checker
   import u8chk_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_byte_present,
   input  wire logic                  req_end_of_text,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output verdict_type                rsp_verdict,
   output logic [LEN_WIDTH-1:0]       rsp_bytes_seen,
   input  wire logic                  csr_write_en,
   input  wire logic [MAX_WIDTH-1:0]  csr_write_data
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_present_ff;
   logic                  in_last_ff;
   logic [MAX_WIDTH-1:0]  max_ff;
   u8chk_state_type       state_ff, state_in;
   u8chk_state_type       state_step;
   verdict_type           verdict_step;
   logic                  out_valid_ff, out_valid_in;
   verdict_type           out_verdict_ff;
   logic [LEN_WIDTH-1:0]  out_len_ff;
   logic                  advance;
   logic                  fire;

   // The second stage moves whenever the response register is free or being drained.
   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance ? (in_valid_ff && in_last_ff) : out_valid_ff;
   assign state_in     = fire ? (in_last_ff ? STATE_CLEAR : state_step) : state_ff;

   u8chk_step u_step (
      .state_cur      (state_ff),
      .data_byte      (in_byte_ff),
      .byte_present   (in_present_ff),
      .max_text_bytes (max_ff),
      .state_nxt      (state_step),
      .verdict        (verdict_step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
         max_ff       <= MAX_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         if (csr_write_en) begin
            max_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff    <= req_data_byte;
         in_present_ff <= req_byte_present;
         in_last_ff    <= req_end_of_text;
      end
      if (fire && in_last_ff) begin
         out_verdict_ff <= verdict_step;
         out_len_ff     <= state_step.len;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_verdict    = out_verdict_ff;
   assign rsp_bytes_seen = out_len_ff;

`ifndef SYNTHESIS
   a_idle_seq_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff.cont_left == 2'd0 |-> state_ff.pos == 2'd0 && state_ff.seq_err == VERDICT_OK)
      else $error("sequence bookkeeping left over outside a sequence");

   a_open_seq_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff.cont_left != 2'd0 |-> state_ff.pos != 2'd0)
      else $error("open sequence without a position");

   a_len_saturates: assert property (@(posedge clock) disable iff (reset)
      state_ff.len[LEN_WIDTH-1] |-> state_ff.len[LEN_WIDTH-2:0] == '0)
      else $error("byte count passed its saturation value");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_verdict == VERDICT_EMPTY) == (rsp_bytes_seen == '0)))
      else $error("empty verdict disagrees with the byte count");

   a_text_clears: assert property (@(posedge clock) disable iff (reset)
      fire && in_last_ff |=> state_ff == STATE_CLEAR)
      else $error("text state not cleared after the end of a text");
`endif

endmodule

`default_nettype wire
